>>> hdl/three_point_circle_radius_assert.svh
// Assertion macros for three_point_circle_radius.sv, which checks its own logic.
// Each macro takes a label, an antecedent and a consequent, and samples on clk
// with the check held off while arst_n is low.
`ifndef THREE_POINT_CIRCLE_RADIUS_ASSERT_SVH
`define THREE_POINT_CIRCLE_RADIUS_ASSERT_SVH
`ifndef SYNTHESIS
`define TPCR_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tpcr check failed");
`define TPCR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tpcr check failed");
`else
`define TPCR_ASSERT_SAME(label, ante, cons)
`define TPCR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hdl/tpcr_pkg.sv
package tpcr_pkg;

	localparam int CW  = 24;  // coordinate width
	localparam int QW  = 26;  // quotient bits resolved by the divider
	localparam int NMW = 76;  // numerator magnitude width
	localparam int DMW = 52;  // denominator magnitude width
	localparam int RMW = DMW + QW;  // divider remainder width
	localparam int RW  = 17;  // radius and register width
	localparam int SW  = 18;  // square root result width
	localparam int SQW = 35;  // width of the squared distance

	localparam logic [RW-1:0] RMIN_RST = 17'd256;
	localparam logic [RW-1:0] RMAX_RST = 17'd128000;

	// Register select, taken from paddr[2].
	localparam logic REG_MIN = 1'b0;
	localparam logic REG_MAX = 1'b1;

	typedef struct packed {
		logic signed [CW-1:0] x1;
		logic signed [CW-1:0] y1;
		logic                 degen;
		logic                 numx_pos;
	} div_side_t;

	typedef struct packed {
		logic degen;
		logic right;
		logic far;
	} sq_side_t;

endpackage

>>> hdl/three_point_circle_radius.sv
// Channel   Direction  Contents
// s_t*      in         request: six signed Q15.8 coordinates, first_x in the lowest bits
// m_t*      out        request: radius (Q8), centre_right, degenerate
// apb       in/out     radius_min at byte 0, radius_max at byte 4
//
// A request passes 58 register stages and ends in the output register:
// seven stages form the bisector terms, 27 go to the bit-per-stage divider,
// four form the squared distance, 19 go to the square root pipeline and one clamps.
// One request enters every cycle; the divider's 26 quotient stages set the depth.
// Reset clears every valid bit and loads the default radius bounds.
// When a result waits at the output and is not taken, the whole pipeline holds.
`include "three_point_circle_radius_assert.svh"

module three_point_circle_radius (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// first_x, first_y, second_x, second_y, third_x, third_y
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// radius[16:0], centre_right[17], degenerate[18], zero fill
	output logic [23:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int CW  = tpcr_pkg::CW;
	localparam int NMW = tpcr_pkg::NMW;
	localparam int DMW = tpcr_pkg::DMW;
	localparam int QW  = tpcr_pkg::QW;
	localparam int RW  = tpcr_pkg::RW;
	localparam int SW  = tpcr_pkg::SW;
	localparam int SQW = tpcr_pkg::SQW;

	// Configuration registers: user writes only while no request in flight; not enforced.
	logic [RW-1:0] rmin_q, rmax_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmin_q <= tpcr_pkg::RMIN_RST;
			rmax_q <= tpcr_pkg::RMAX_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				tpcr_pkg::REG_MIN: rmin_q <= pwdata[RW-1:0];
				tpcr_pkg::REG_MAX: rmax_q <= pwdata[RW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			tpcr_pkg::REG_MIN: prdata = 32'(rmin_q);
			tpcr_pkg::REG_MAX: prdata = 32'(rmax_q);
			default:           prdata = '0;
		endcase
	end

	// Every stage moves together; the output register is the only place where
	// a result can wait, and while it waits untaken the pipeline stands still.
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic signed [CW-1:0] x1, y1, x2, y2, x3, y3;
	assign x1 = s_tdata[23:0];
	assign y1 = s_tdata[47:24];
	assign x2 = s_tdata[71:48];
	assign y2 = s_tdata[95:72];
	assign x3 = s_tdata[119:96];
	assign y3 = s_tdata[143:120];

	// Stage 1: differences and sums of coordinates. The chord terms c and f
	// are built as (x2 - x1)(x2 + x1) + (y2 - y1)(y2 + y1), so every product
	// stays within 25 by 25 bits.
	logic                vld_s1;
	logic signed [24:0]  dx21_s1, dy21_s1, dx32_s1, dy32_s1;
	logic signed [24:0]  sx21_s1, sy21_s1, sx32_s1, sy32_s1;
	tpcr_pkg::div_side_t side_s1;

	// Stage 2: difference-by-sum products; a, b, d, e are twice the differences.
	logic                vld_s2;
	logic signed [49:0]  px21_s2, py21_s2, px32_s2, py32_s2;
	logic signed [25:0]  a_s2, b_s2, d_s2, e_s2;
	tpcr_pkg::div_side_t side_s2;

	// Stage 3: c, f and the two halves of the denominator.
	logic                vld_s3;
	logic signed [49:0]  c_s3, f_s3;
	logic signed [51:0]  bd_s3, ea_s3;
	logic signed [25:0]  a_s3, b_s3, d_s3, e_s3;
	tpcr_pkg::div_side_t side_s3;

	// Stage 4: the wide products, each cut into a low and a high partial.
	logic                vld_s4;
	logic signed [51:0]  bfl_s4, ecl_s4, dcl_s4, afl_s4;
	logic signed [50:0]  bfh_s4, ech_s4, dch_s4, afh_s4;
	logic signed [52:0]  den_s4;
	tpcr_pkg::div_side_t side_s4;

	// Stage 5: partials recombined; denominator sign and magnitude.
	logic                vld_s5;
	logic signed [76:0]  bf_s5, ec_s5, dc_s5, af_s5;
	logic [DMW-1:0]      dmag_s5;
	logic                dneg_s5;
	tpcr_pkg::div_side_t side_s5;

	// Stage 6: the two numerators.
	logic                vld_s6;
	logic signed [76:0]  numx_s6, numy_s6;
	logic [DMW-1:0]      dmag_s6;
	logic                dneg_s6;
	tpcr_pkg::div_side_t side_s6;

	// Stage 7: numerator magnitudes and quotient signs for the divider.
	logic                vld_s7;
	logic [1:0][NMW-1:0] nmag_s7;
	logic [1:0]          qneg_s7;
	logic [DMW-1:0]      dmag_s7;
	tpcr_pkg::div_side_t side_s7;

	logic signed [76:0]  nx_abs, ny_abs;
	assign nx_abs = numx_s6[76] ? -numx_s6 : numx_s6;
	assign ny_abs = numy_s6[76] ? -numy_s6 : numy_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx21_s1 <= 25'(x2) - 25'(x1);
			dy21_s1 <= 25'(y2) - 25'(y1);
			dx32_s1 <= 25'(x3) - 25'(x2);
			dy32_s1 <= 25'(y3) - 25'(y2);
			sx21_s1 <= 25'(x2) + 25'(x1);
			sy21_s1 <= 25'(y2) + 25'(y1);
			sx32_s1 <= 25'(x3) + 25'(x2);
			sy32_s1 <= 25'(y3) + 25'(y2);
			side_s1 <= '{x1: x1, y1: y1, degen: 1'b0, numx_pos: 1'b0};

			px21_s2 <= dx21_s1 * sx21_s1;
			py21_s2 <= dy21_s1 * sy21_s1;
			px32_s2 <= dx32_s1 * sx32_s1;
			py32_s2 <= dy32_s1 * sy32_s1;
			a_s2    <= $signed({dx21_s1, 1'b0});
			b_s2    <= $signed({dy21_s1, 1'b0});
			d_s2    <= $signed({dx32_s1, 1'b0});
			e_s2    <= $signed({dy32_s1, 1'b0});
			side_s2 <= side_s1;

			c_s3    <= px21_s2 + py21_s2;
			f_s3    <= px32_s2 + py32_s2;
			bd_s3   <= b_s2 * d_s2;
			ea_s3   <= e_s2 * a_s2;
			a_s3    <= a_s2;
			b_s3    <= b_s2;
			d_s3    <= d_s2;
			e_s3    <= e_s2;
			side_s3 <= side_s2;

			bfl_s4  <= b_s3 * $signed({1'b0, f_s3[24:0]});
			ecl_s4  <= e_s3 * $signed({1'b0, c_s3[24:0]});
			dcl_s4  <= d_s3 * $signed({1'b0, c_s3[24:0]});
			afl_s4  <= a_s3 * $signed({1'b0, f_s3[24:0]});
			bfh_s4  <= b_s3 * $signed(f_s3[49:25]);
			ech_s4  <= e_s3 * $signed(c_s3[49:25]);
			dch_s4  <= d_s3 * $signed(c_s3[49:25]);
			afh_s4  <= a_s3 * $signed(f_s3[49:25]);
			den_s4  <= 53'(bd_s3) - 53'(ea_s3);
			side_s4 <= side_s3;

			bf_s5   <= (77'(bfh_s4) <<< 25) + 77'(bfl_s4);
			ec_s5   <= (77'(ech_s4) <<< 25) + 77'(ecl_s4);
			dc_s5   <= (77'(dch_s4) <<< 25) + 77'(dcl_s4);
			af_s5   <= (77'(afh_s4) <<< 25) + 77'(afl_s4);
			dmag_s5 <= den_s4[52] ? DMW'(-den_s4) : DMW'(den_s4);
			dneg_s5 <= den_s4[52];
			side_s5 <= '{x1: side_s4.x1, y1: side_s4.y1,
				degen: (den_s4 == '0), numx_pos: 1'b0};

			numx_s6 <= bf_s5 - ec_s5;
			numy_s6 <= dc_s5 - af_s5;
			dmag_s6 <= dmag_s5;
			dneg_s6 <= dneg_s5;
			side_s6 <= side_s5;

			nmag_s7[0] <= nx_abs[NMW-1:0];
			nmag_s7[1] <= ny_abs[NMW-1:0];
			qneg_s7[0] <= numx_s6[76] ^ dneg_s6;
			qneg_s7[1] <= numy_s6[76] ^ dneg_s6;
			dmag_s7    <= dmag_s6;
			side_s7    <= '{x1: side_s6.x1, y1: side_s6.y1, degen: side_s6.degen,
				numx_pos: !numx_s6[76] && (numx_s6 != '0)};
		end
	end

	// Both centre coordinates are divided side by side in one shared pipeline.
	logic                vld_dv;
	logic [1:0][QW-1:0]  q_dv;
	logic [1:0]          far_dv, neg_dv;
	tpcr_pkg::div_side_t side_dv;

	tpcr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s7),
		.un        (nmag_s7),
		.ud        (dmag_s7),
		.neg       (qneg_s7),
		.side      (side_s7),
		.out_valid (vld_dv),
		.q         (q_dv),
		.far       (far_dv),
		.neg_o     (neg_dv),
		.side_o    (side_dv)
	);

	// Stage a: signed centre and its offset from the first point.
	logic signed [26:0] cx, cy;
	assign cx = neg_dv[0] ? -$signed({1'b0, q_dv[0]}) : $signed({1'b0, q_dv[0]});
	assign cy = neg_dv[1] ? -$signed({1'b0, q_dv[1]}) : $signed({1'b0, q_dv[1]});

	logic               vld_sa;
	logic signed [27:0] offx_sa, offy_sa;
	logic [1:0]         far_sa;
	tpcr_pkg::sq_side_t side_sa;

	// Stage b: offset magnitudes, flagged far when they exceed the radius width.
	logic signed [27:0] offx_abs, offy_abs;
	assign offx_abs = offx_sa[27] ? -offx_sa : offx_sa;
	assign offy_abs = offy_sa[27] ? -offy_sa : offy_sa;

	logic               vld_sb;
	logic [RW-1:0]      magx_sb, magy_sb;
	tpcr_pkg::sq_side_t side_sb;

	// Stages c and d: squares, then their sum.
	logic               vld_sc;
	logic [2*RW-1:0]    sqx_sc, sqy_sc;
	tpcr_pkg::sq_side_t side_sc;

	logic               vld_sd;
	logic [SQW-1:0]     sum_sd;
	tpcr_pkg::sq_side_t side_sd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sa <= 1'b0;
			vld_sb <= 1'b0;
			vld_sc <= 1'b0;
			vld_sd <= 1'b0;
		end else if (en) begin
			vld_sa <= vld_dv;
			vld_sb <= vld_sa;
			vld_sc <= vld_sb;
			vld_sd <= vld_sc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			offx_sa <= 28'(cx) - 28'(side_dv.x1);
			offy_sa <= 28'(cy) - 28'(side_dv.y1);
			far_sa  <= far_dv;
			// A degenerate triple reports the sign of the x numerator instead.
			side_sa <= '{degen: side_dv.degen,
				right: side_dv.degen ? side_dv.numx_pos
					: (!neg_dv[0] && (far_dv[0] || (q_dv[0] != '0))),
				far: 1'b0};

			magx_sb <= offx_abs[RW-1:0];
			magy_sb <= offy_abs[RW-1:0];
			side_sb <= '{degen: side_sa.degen, right: side_sa.right,
				far: (|far_sa) || (offx_abs[27:RW] != '0) || (offy_abs[27:RW] != '0)};

			sqx_sc  <= magx_sb * magx_sb;
			sqy_sc  <= magy_sb * magy_sb;
			side_sc <= side_sb;

			sum_sd  <= SQW'(sqx_sc) + SQW'(sqy_sc);
			side_sd <= side_sc;
		end
	end

	logic               vld_rt;
	logic [SW-1:0]      root_rt;
	tpcr_pkg::sq_side_t side_rt;

	tpcr_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_sd),
		.v         (sum_sd),
		.side      (side_sd),
		.out_valid (vld_rt),
		.root      (root_rt),
		.side_o    (side_rt)
	);

	// Final stage: upper clamp first, then lower clamp, as the bounds may cross.
	logic [RW-1:0] radius_d;
	always_comb begin
		if (side_rt.degen || side_rt.far || (root_rt > SW'(rmax_q))) begin
			radius_d = rmax_q;
		end else if (root_rt < SW'(rmin_q)) begin
			radius_d = rmin_q;
		end else begin
			radius_d = root_rt[RW-1:0];
		end
	end

	logic          out_vld_q;
	logic [23:0]   out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_rt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {5'b0, side_rt.degen, side_rt.right, radius_d};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	// A degenerate triple always reports the upper bound.
	`TPCR_ASSERT_SAME(a_degen_max, m_tvalid && m_tdata[18], m_tdata[16:0] == rmax_q)
	// With ordered bounds every radius lies between them.
	`TPCR_ASSERT_SAME(a_in_bounds, m_tvalid && (rmin_q <= rmax_q),
		(m_tdata[16:0] >= rmin_q) && (m_tdata[16:0] <= rmax_q))
	// While the output waits, nothing inside the pipeline moves.
	`TPCR_ASSERT_NEXT(a_stall_hold, !en, $stable(vld_sd) && $stable(vld_s7))

endmodule

>>> hdl/tpcr_div.sv
module tpcr_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic [1:0][tpcr_pkg::NMW-1:0]        un,
	input  logic [tpcr_pkg::DMW-1:0]             ud,
	input  logic [1:0]                           neg,
	input  tpcr_pkg::div_side_t                  side,
	output logic                                 out_valid,
	output logic [1:0][tpcr_pkg::QW-1:0]         q,
	output logic [1:0]                           far,
	output logic [1:0]                           neg_o,
	output tpcr_pkg::div_side_t                  side_o
);

	localparam int QW  = tpcr_pkg::QW;
	localparam int RMW = tpcr_pkg::RMW;
	localparam int DMW = tpcr_pkg::DMW;

	logic                       vld_s  [0:QW];
	logic [1:0][RMW-1:0]        rem_s  [0:QW];
	logic [1:0][QW-1:0]         quo_s  [0:QW];
	logic [DMW-1:0]             ud_s   [0:QW];
	logic [1:0]                 far_s  [0:QW];
	logic [1:0]                 neg_s  [0:QW];
	tpcr_pkg::div_side_t        side_s [0:QW];
	logic [RMW-1:0]             trial  [0:QW-1];
	logic [RMW-1:0]             limit;

	// A quotient of 2^QW or more puts the centre far beyond any radius.
	assign limit = RMW'(ud) << QW;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ud_s[0]   <= ud;
			neg_s[0]  <= neg;
			side_s[0] <= side;
			quo_s[0]  <= '0;
			for (int l = 0; l < 2; l++) begin
				rem_s[0][l] <= RMW'(un[l]);
				far_s[0][l] <= RMW'(un[l]) >= limit;
			end
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_step
		localparam int K = QW - 1 - i;

		assign trial[i] = RMW'(ud_s[i]) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ud_s[i+1]   <= ud_s[i];
				neg_s[i+1]  <= neg_s[i];
				far_s[i+1]  <= far_s[i];
				side_s[i+1] <= side_s[i];
				for (int l = 0; l < 2; l++) begin
					if (rem_s[i][l] >= trial[i]) begin
						rem_s[i+1][l] <= rem_s[i][l] - trial[i];
						quo_s[i+1][l] <= quo_s[i][l] | (QW'(1) << K);
					end else begin
						rem_s[i+1][l] <= rem_s[i][l];
						quo_s[i+1][l] <= quo_s[i][l];
					end
				end
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign q         = quo_s[QW];
	assign far       = far_s[QW];
	assign neg_o     = neg_s[QW];
	assign side_o    = side_s[QW];

endmodule

>>> hdl/tpcr_sqrt.sv
module tpcr_sqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [tpcr_pkg::SQW-1:0] v,
	input  tpcr_pkg::sq_side_t       side,
	output logic                     out_valid,
	output logic [tpcr_pkg::SW-1:0]  root,
	output tpcr_pkg::sq_side_t       side_o
);

	localparam int SW = tpcr_pkg::SW;
	localparam int XW = tpcr_pkg::SQW + 1;

	logic               vld_s  [0:SW];
	logic [XW-1:0]      val_s  [0:SW];
	logic [XW-1:0]      res_s  [0:SW];
	tpcr_pkg::sq_side_t side_s [0:SW];
	logic [XW-1:0]      trial  [0:SW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s[0]  <= XW'(v);
			res_s[0]  <= '0;
			side_s[0] <= side;
		end
	end

	for (genvar i = 0; i < SW; i++) begin : g_step
		localparam int K = SW - 1 - i;
		localparam logic [XW-1:0] BIT = XW'(1) << (2 * K);

		assign trial[i] = res_s[i] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i+1] <= side_s[i];
				if (val_s[i] >= trial[i]) begin
					val_s[i+1] <= val_s[i] - trial[i];
					res_s[i+1] <= (res_s[i] >> 1) + BIT;
				end else begin
					val_s[i+1] <= val_s[i];
					res_s[i+1] <= res_s[i] >> 1;
				end
			end
		end
	end

	assign out_valid = vld_s[SW];
	assign root      = res_s[SW][SW-1:0];
	assign side_o    = side_s[SW];

endmodule
